@@ hdl/nfcs_pkg.sv @@
`timescale 1ns / 1ps
package nfcs_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_PROG   = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_CHECK  = 3'd3,
        CMD_RDATA  = 3'd4,
        CMD_TICK   = 3'd5,
        CMD_QUERY  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        M_IDLE  = 2'd0,
        M_PROG  = 2'd1,
        M_ERASE = 2'd2,
        M_CHECK = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_SEARCH,
        S_SRCH_WAIT,
        S_CHK_RD,
        S_CHK_WAIT,
        S_ET_WAIT
    } t_state;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_RANGE     = 4'd1;
    localparam logic [3:0] ST_NO_SECTOR = 4'd2;
    localparam logic [3:0] ST_PROG_FAIL = 4'd3;
    localparam logic [3:0] ST_TIMEOUT   = 4'd4;
    localparam logic [3:0] ST_EXHAUSTED = 4'd5;
    localparam logic [3:0] ST_MAKER     = 4'd6;
    localparam logic [3:0] ST_DEVICE    = 4'd7;
    localparam logic [3:0] ST_PROTECTED = 4'd8;

    localparam logic [2:0] CFG_BASE   = 3'd0;
    localparam logic [2:0] CFG_LENGTH = 3'd1;
    localparam logic [2:0] CFG_COUNT  = 3'd2;
    localparam logic [2:0] CFG_DEVID  = 3'd3;
    localparam logic [2:0] CFG_MAKER  = 3'd4;
    localparam logic [2:0] CFG_PROT   = 3'd5;
    localparam logic [2:0] CFG_TMO    = 3'd6;

    localparam logic [15:0] D_RESET  = 16'hf0f0;
    localparam logic [15:0] D_UNLK1  = 16'haaaa;
    localparam logic [15:0] D_UNLK2  = 16'h5555;
    localparam logic [15:0] D_ERASE  = 16'h8080;
    localparam logic [15:0] D_SECTOR = 16'h3030;
    localparam logic [15:0] D_PROG   = 16'ha0a0;
    localparam logic [15:0] D_AUTO   = 16'h9090;
    localparam logic [15:0] D_ERASED = 16'hffff;
    localparam logic [19:0] A_UNLK1  = 20'haaa;
    localparam logic [19:0] A_UNLK2  = 20'h554;

    // one queued result
    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [19:0] off;
        logic [15:0] data;
        logic        done;
        logic [3:0]  st;
        logic [15:0] ticks;
    } t_res;

endpackage

@@ hdl/nor_flash_command_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Output: an item's results leave one per cycle while i_stall is low, after acceptance.
// Erase walks the sector table one entry at a time via S_SEARCH and S_SRCH_WAIT; check
// reads one table entry per sector read; query waits in S_ET_WAIT on the erase-time RAM.
// Throughput: one item at a time, input stalled until all its results are taken.
// Reset (synchronous, active low) clears control state and erase-time valid bits and
// sets configuration to defaults; sector bound memories are undefined until loaded.
module nor_flash_command_sequencer_unit #(
    parameter int MAX_SECTORS        = 32,
    parameter int ERASE_POLL_LIMIT   = 500000,
    parameter int PROGRAM_POLL_LIMIT = 1000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [20:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_command,
    input  logic [23:0]           i_address,
    input  logic [15:0]           i_word_data,
    input  logic [4:0]            i_sector_index,
    input  logic [20:0]           i_sector_start,
    input  logic [20:0]           i_sector_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_bus_write,
    output logic                  o_bus_read,
    output logic [19:0]           o_bus_offset,
    output logic [15:0]           o_bus_data,
    output logic                  o_done_res,
    output logic [3:0]            o_status,
    output logic [15:0]           o_erase_ticks,
    output logic                  o_last
);
    import nfcs_pkg::*;

    localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CW = $clog2(MAX_SECTORS + 1);
    localparam int PW = 19;
    localparam logic [PW-1:0] EPL = PW'(ERASE_POLL_LIMIT);
    localparam logic [PW-1:0] PPL = PW'(PROGRAM_POLL_LIMIT);

    // configuration
    logic [3:0]  r_base;
    logic [20:0] r_len;
    logic [5:0]  r_scnt;
    logic [15:0] r_devid;
    logic [7:0]  r_maker, r_prot;
    logic [15:0] r_tmo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0; r_len <= 21'd1048576; r_scnt <= 6'd19;
            r_devid <= '0; r_maker <= 8'd1; r_prot <= 8'd1; r_tmo <= 16'd30000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:   r_base  <= i_cfg_data[3:0];
                CFG_LENGTH: r_len   <= i_cfg_data;
                CFG_COUNT:  r_scnt  <= i_cfg_data[5:0];
                CFG_DEVID:  r_devid <= i_cfg_data[15:0];
                CFG_MAKER:  r_maker <= i_cfg_data[7:0];
                CFG_PROT:   r_prot  <= i_cfg_data[7:0];
                CFG_TMO:    r_tmo   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] w_active;
    assign w_active = ({1'b0, r_scnt} < 7'(MAX_SECTORS)) ? CW'(r_scnt) : CW'(MAX_SECTORS);

    // state
    t_state        r_state, n_state;
    t_mode         r_mode;
    logic [1:0]    r_phase;
    logic [PW-1:0] r_poll;
    logic          r_first;
    logic [15:0]   r_tword;
    logic [19:0]   r_toff;
    logic [CW-1:0] r_cur;
    logic [15:0]   r_timer;
    logic [20:0]   r_soff;
    logic [4:0]    r_qidx;
    logic [MAX_SECTORS-1:0] r_etv;

    // result queue (up to 8 per item)
    t_res       r_q [8];
    logic [3:0] r_qn;
    logic [2:0] r_qi;

    // memories
    logic          w_sw_we;
    logic [AW-1:0] w_sw_addr, w_rd_addr;
    logic [20:0]   w_st_rd, w_en_rd;
    logic          w_et_we;
    logic [AW-1:0] w_et_waddr, w_et_raddr;
    logic [15:0]   w_et_wdata, w_et_rd;

    nfcs_ram #(.WIDTH(21), .DEPTH(MAX_SECTORS)) u_starts (
        .i_clk(i_clk), .i_we(w_sw_we), .i_waddr(w_sw_addr), .i_wdata(i_sector_start),
        .i_raddr(w_rd_addr), .o_rdata(w_st_rd));
    nfcs_ram #(.WIDTH(21), .DEPTH(MAX_SECTORS)) u_ends (
        .i_clk(i_clk), .i_we(w_sw_we), .i_waddr(w_sw_addr), .i_wdata(i_sector_end),
        .i_raddr(w_rd_addr), .o_rdata(w_en_rd));
    nfcs_ram #(.WIDTH(16), .DEPTH(MAX_SECTORS)) u_etime (
        .i_clk(i_clk), .i_we(w_et_we), .i_waddr(w_et_waddr), .i_wdata(w_et_wdata),
        .i_raddr(w_et_raddr), .o_rdata(w_et_rd));

    logic w_acc;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = (r_state == S_EMIT);

    t_res w_head;
    assign w_head        = r_q[r_qi];
    assign o_bus_write   = w_head.wr;
    assign o_bus_read    = w_head.rd;
    assign o_bus_offset  = w_head.off;
    assign o_bus_data    = w_head.data;
    assign o_done_res    = w_head.done;
    assign o_status      = w_head.st;
    assign o_erase_ticks = w_head.ticks;
    assign o_last        = ({1'b0, r_qi} == r_qn - 4'd1);

    // window check
    logic [24:0] w_base_a, w_base_end;
    logic        w_inwin;
    logic [19:0] w_off;
    logic [20:0] w_soff;
    assign w_base_a   = {1'b0, r_base, 20'd0};
    assign w_base_end = w_base_a + 25'(r_len);
    assign w_inwin    = ({1'b0, i_address} >= w_base_a) && ({1'b0, i_address} < w_base_end);
    assign w_off      = i_address[19:0];
    // full offset for the table compare; the window can reach past 1 MiB
    assign w_soff     = i_address[20:0] - {r_base[0], 20'd0};

    logic [AW-1:0] w_cur_a;
    assign w_cur_a    = r_cur[AW-1:0];
    assign w_sw_we    = w_acc && (i_command == CMD_LOAD) && (r_mode == M_IDLE)
                        && ({2'b0, i_sector_index} < 7'(MAX_SECTORS));
    assign w_sw_addr  = AW'(i_sector_index);
    assign w_rd_addr  = w_cur_a;
    // present the query index at acceptance so the registered read data is ready in S_ET_WAIT
    assign w_et_raddr = (r_state == S_IDLE) ? AW'(i_sector_index) : AW'(r_qidx);

    // combinational item decode
    t_res          n_q [8];
    logic [3:0]    n_qn;
    t_mode         n_mode;
    logic [1:0]    n_phase;
    logic [PW-1:0] n_poll;
    logic          n_first;
    logic [15:0]   n_tword, n_timer;
    logic [19:0]   n_toff;
    logic [20:0]   n_soff;
    logic [CW-1:0] n_cur;
    logic [4:0]    n_qidx;

    function automatic t_res mk(input logic w, input logic r, input logic [19:0] o,
                                input logic [15:0] d, input logic dn,
                                input logic [3:0] s, input logic [15:0] t);
        t_res x;
        x.wr = w; x.rd = r; x.off = o; x.data = d; x.done = dn; x.st = s; x.ticks = t;
        return x;
    endfunction

    always_comb begin
        t_res z;
        z = mk(1'b0, 1'b0, '0, '0, 1'b0, '0, '0);
        for (int k = 0; k < 8; k++) n_q[k] = r_q[k];
        n_qn = r_qn; n_mode = r_mode; n_phase = r_phase; n_poll = r_poll;
        n_first = r_first; n_tword = r_tword; n_toff = r_toff; n_cur = r_cur;
        n_timer = r_timer; n_soff = r_soff; n_qidx = r_qidx; n_state = r_state;
        w_et_we = 1'b0; w_et_waddr = w_cur_a;
        w_et_wdata = r_tmo - r_timer;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_qn = 4'd0; n_state = S_EMIT;
                    for (int k = 0; k < 8; k++) n_q[k] = z;
                    case (i_command)
                        CMD_LOAD: begin
                            if (r_mode != M_IDLE) n_state = S_IDLE;
                            else begin
                                n_q[0] = mk(0, 0, '0, '0, 1,
                                    ({2'b0, i_sector_index} < 7'(MAX_SECTORS))
                                    ? ST_OK : ST_NO_SECTOR, '0);
                                n_qn = 4'd1;
                            end
                        end
                        CMD_PROG: begin
                            if (r_mode != M_IDLE) n_state = S_IDLE;
                            else if (!w_inwin || i_address[0]) begin
                                n_q[0] = mk(0, 0, '0, '0, 1, ST_RANGE, '0); n_qn = 4'd1;
                            end else begin
                                n_toff = w_off; n_tword = i_word_data;
                                n_q[0] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                                n_q[1] = mk(1, 0, A_UNLK1, D_UNLK1, 0, '0, '0);
                                n_q[2] = mk(1, 0, A_UNLK2, D_UNLK2, 0, '0, '0);
                                n_q[3] = mk(1, 0, A_UNLK1, D_PROG, 0, '0, '0);
                                n_q[4] = mk(1, 0, w_off, i_word_data, 0, '0, '0);
                                n_first = 1'b0; n_mode = M_PROG;
                                if (PPL == '0) begin
                                    n_q[5] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                                    n_q[6] = mk(0, 0, '0, '0, 1, ST_PROG_FAIL, '0);
                                    n_qn = 4'd7; n_mode = M_IDLE; n_phase = '0;
                                end else begin
                                    n_poll = PPL - PW'(1);
                                    n_q[5] = mk(0, 1, w_off, '0, 0, '0, '0); n_qn = 4'd6;
                                end
                            end
                        end
                        CMD_ERASE: begin
                            if (r_mode != M_IDLE) n_state = S_IDLE;
                            else if (!w_inwin) begin
                                n_q[0] = mk(0, 0, '0, '0, 1, ST_RANGE, '0); n_qn = 4'd1;
                            end else begin
                                n_soff = w_soff; n_cur = '0; n_state = S_SEARCH;
                            end
                        end
                        CMD_CHECK: begin
                            if (r_mode != M_IDLE) n_state = S_IDLE;
                            else begin
                                n_q[0] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                                n_q[1] = mk(1, 0, A_UNLK1, D_UNLK1, 0, '0, '0);
                                n_q[2] = mk(1, 0, A_UNLK2, D_UNLK2, 0, '0, '0);
                                n_q[3] = mk(1, 0, A_UNLK1, D_AUTO, 0, '0, '0);
                                n_q[4] = mk(0, 1, '0, '0, 0, '0, '0);
                                n_qn = 4'd5; n_mode = M_CHECK; n_phase = '0; n_cur = '0;
                            end
                        end
                        CMD_RDATA: begin
                            if (r_mode == M_PROG || r_mode == M_ERASE) begin
                                if (i_word_data != r_tword) begin
                                    // new poll round
                                    n_first = 1'b0;
                                    if (r_poll == '0) begin
                                        if (r_mode == M_PROG) begin
                                            n_q[0] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                                            n_q[1] = mk(0, 0, '0, '0, 1, ST_PROG_FAIL, '0);
                                            n_qn = 4'd2;
                                        end else begin
                                            n_q[0] = mk(0, 0, '0, '0, 1, ST_EXHAUSTED, '0);
                                            n_qn = 4'd1;
                                        end
                                        n_mode = M_IDLE; n_phase = '0;
                                    end else begin
                                        n_poll = r_poll - PW'(1);
                                        if (r_mode == M_ERASE && r_timer == '0) begin
                                            n_q[0] = mk(0, 0, '0, '0, 1, ST_TIMEOUT, '0);
                                            n_mode = M_IDLE; n_phase = '0;
                                        end else begin
                                            n_q[0] = mk(0, 1, r_toff, '0, 0, '0, '0);
                                        end
                                        n_qn = 4'd1;
                                    end
                                end else if (!r_first) begin
                                    n_first = 1'b1;
                                    n_q[0] = mk(0, 1, r_toff, '0, 0, '0, '0); n_qn = 4'd1;
                                end else begin
                                    if (r_mode == M_PROG) begin
                                        n_q[0] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                                        n_q[1] = mk(0, 0, '0, '0, 1, ST_OK, '0);
                                        n_qn = 4'd2;
                                    end else begin
                                        w_et_we = 1'b1;
                                        n_q[0] = mk(0, 0, '0, '0, 1, ST_OK, '0);
                                        n_qn = 4'd1;
                                    end
                                    n_mode = M_IDLE; n_phase = '0; n_first = 1'b0;
                                end
                            end else if (r_mode == M_CHECK) begin
                                case (r_phase)
                                    2'd0: begin
                                        if (i_word_data[7:0] != r_maker) begin
                                            n_q[0] = mk(0, 0, '0, '0, 1, ST_MAKER, '0);
                                            n_qn = 4'd1; n_mode = M_IDLE; n_first = 1'b0;
                                        end else begin
                                            n_phase = 2'd1;
                                            n_q[0] = mk(0, 1, 20'd2, '0, 0, '0, '0);
                                            n_qn = 4'd1;
                                        end
                                    end
                                    2'd1: begin
                                        if (i_word_data != r_devid) begin
                                            n_q[0] = mk(0, 0, '0, '0, 1, ST_DEVICE, '0);
                                            n_qn = 4'd1; n_mode = M_IDLE; n_phase = '0;
                                            n_first = 1'b0;
                                        end else begin
                                            n_phase = 2'd2; n_cur = '0; n_state = S_CHK_RD;
                                        end
                                    end
                                    default: begin
                                        if (i_word_data[7:0] == r_prot) begin
                                            n_q[0] = mk(0, 0, '0, '0, 1, ST_PROTECTED, '0);
                                            n_qn = 4'd1; n_mode = M_IDLE; n_phase = '0;
                                            n_first = 1'b0;
                                        end else begin
                                            n_cur = r_cur + CW'(1); n_state = S_CHK_RD;
                                        end
                                    end
                                endcase
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        CMD_TICK: begin
                            if (r_timer != '0) n_timer = r_timer - 16'd1;
                            n_state = S_IDLE;
                        end
                        CMD_QUERY: begin
                            n_qidx = i_sector_index; n_state = S_ET_WAIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_cur >= w_active) begin
                    n_q[0] = mk(0, 0, '0, '0, 1, ST_NO_SECTOR, '0); n_qn = 4'd1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRCH_WAIT;
                end
            end
            S_SRCH_WAIT: begin
                if (r_soff >= w_st_rd && r_soff < w_en_rd) begin
                    n_toff = w_st_rd[19:0]; n_tword = D_ERASED;
                    n_q[0] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                    n_q[1] = mk(1, 0, A_UNLK1, D_UNLK1, 0, '0, '0);
                    n_q[2] = mk(1, 0, A_UNLK2, D_UNLK2, 0, '0, '0);
                    n_q[3] = mk(1, 0, A_UNLK1, D_ERASE, 0, '0, '0);
                    n_q[4] = mk(1, 0, A_UNLK1, D_UNLK1, 0, '0, '0);
                    n_q[5] = mk(1, 0, A_UNLK2, D_UNLK2, 0, '0, '0);
                    n_q[6] = mk(1, 0, w_st_rd[19:0], D_SECTOR, 0, '0, '0);
                    n_timer = r_tmo; n_first = 1'b0; n_qn = 4'd8; n_state = S_EMIT;
                    if (EPL == '0) begin
                        n_q[7] = mk(0, 0, '0, '0, 1, ST_EXHAUSTED, '0);
                        n_mode = M_IDLE; n_phase = '0;
                    end else begin
                        n_poll = EPL - PW'(1); n_mode = M_ERASE;
                        if (r_tmo == '0) begin
                            n_q[7] = mk(0, 0, '0, '0, 1, ST_TIMEOUT, '0);
                            n_mode = M_IDLE; n_phase = '0;
                        end else begin
                            n_q[7] = mk(0, 1, w_st_rd[19:0], '0, 0, '0, '0);
                        end
                    end
                end else begin
                    n_cur = r_cur + CW'(1); n_state = S_SEARCH;
                end
            end
            S_CHK_RD: begin
                if (r_cur >= w_active) begin
                    n_q[0] = mk(1, 0, '0, D_RESET, 0, '0, '0);
                    n_q[1] = mk(0, 0, '0, '0, 1, ST_OK, '0);
                    n_qn = 4'd2; n_mode = M_IDLE; n_phase = '0; n_first = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CHK_WAIT;
                end
            end
            S_CHK_WAIT: begin
                n_q[0] = mk(0, 1, w_st_rd[19:0] + 20'd4, '0, 0, '0, '0);
                n_qn = 4'd1; n_state = S_EMIT;
            end
            S_ET_WAIT: begin
                n_q[0] = mk(0, 0, '0, '0, 1, ST_OK,
                    ({2'b0, r_qidx} < 7'(w_active) && r_etv[w_et_raddr]) ? w_et_rd : '0);
                n_qn = 4'd1; n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall && ({1'b0, r_qi} == r_qn - 4'd1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= M_IDLE; r_phase <= '0; r_poll <= '0;
            r_first <= 1'b0; r_tword <= '0; r_toff <= '0; r_cur <= '0;
            r_timer <= '0; r_qn <= '0; r_qi <= '0; r_etv <= '0;
        end else begin
            r_state <= n_state; r_mode <= n_mode; r_phase <= n_phase;
            r_poll <= n_poll; r_first <= n_first; r_tword <= n_tword;
            r_toff <= n_toff; r_cur <= n_cur; r_timer <= n_timer; r_qn <= n_qn;
            if (w_et_we) r_etv[w_et_waddr] <= 1'b1;
            if (r_state == S_EMIT && !i_stall) r_qi <= r_qi + 3'd1;
            else if (r_state != S_EMIT) r_qi <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) r_q[k] <= n_q[k];
        r_soff <= n_soff; r_qidx <= n_qidx;
    end
endmodule

@@ hdl/nfcs_ram.sv @@
`timescale 1ns / 1ps
module nfcs_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
